// ----- rtl/led_pattern_flasher_unit_defines.svh -----
// assertion macros shared by the led pattern flasher rtl
`ifndef LED_PATTERN_FLASHER_UNIT_DEFINES_SVH
`define LED_PATTERN_FLASHER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpf assertion failed");

// next-cycle implication, disabled while in reset
`define LPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpf assertion failed");

`endif

// ----- rtl/lpf_pkg.sv -----
// types and constants of the led pattern flasher
`default_nettype none

package lpf_pkg;

  localparam logic [7:0] ManualPeriod = 8'd250;
  localparam logic [7:0] ManualHigh   = 8'd230;
  localparam logic [7:0] ManualLow    = 8'd10;
  localparam logic [7:0] BeepPattern  = 8'h55;
  localparam logic [7:0] BeepPeriod   = 8'd25;
  localparam logic [7:0] CursorTop    = 8'h80;

  // bit positions in mode_flags
  localparam int unsigned FlagTestOn  = 0;
  localparam int unsigned FlagTestOff = 1;
  localparam int unsigned FlagBeep0   = 2;
  localparam int unsigned FlagInvert0 = 4;
  localparam int unsigned FlagOnboard = 6;

  typedef enum logic [2:0] {
    CFG_MODE_FLAGS,
    CFG_DEBUG_MASK,
    CFG_PERIOD_0,
    CFG_PATTERN_0,
    CFG_PERIOD_1,
    CFG_PATTERN_1
  } cfg_idx_t;

  typedef struct packed {
    logic test_on;
    logic test_off;
    logic beep_sel;
    logic debug_en;
    logic dbg_hit;
    logic onboard_en;
  } lpf_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/led_pattern_flasher_unit.sv -----
// top level of the led pattern flasher: config registers, input and result registers
`default_nettype none
`include "led_pattern_flasher_unit_defines.svh"

// Two-channel LED flasher. Each accepted request is one update tick and
// produces exactly one result with both pin levels (after the invert bits)
// and the onboard LED copies. A request is captured in an input register;
// the per-channel source selection and flasher counter update are one short
// combinational stage from there into the result register and the channel
// state, so a request can be accepted every cycle while in_stall is low.
// Its result is loaded into the result register when that register can
// advance. While a finished result waits under out_stall the input
// register can take one more request; after that in_stall rises until the
// result is taken. Configuration writes are always ready and take effect
// on the next tick; they should only be made while no request is in flight.
module led_pattern_flasher_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_beep_active,
  input  logic [7:0] in_debug_bits_0,
  input  logic [7:0] in_debug_bits_1,
  input  logic [7:0] in_manual_level_0,
  input  logic [7:0] in_manual_level_1,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pin_0,
  output logic       out_pin_1,
  output logic       out_red_led,
  output logic       out_green_led,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import lpf_pkg::*;

  logic [6:0] mode_r;
  logic [7:0] dbg_mask_r;
  logic [7:0] period0_r, period1_r;
  logic [7:0] pattern0_r, pattern1_r;

  logic       s1_valid_r;
  logic       s1_beep_r;
  logic [7:0] s1_dbg0_r, s1_dbg1_r;
  logic [7:0] s1_man0_r, s1_man1_r;

  logic out_valid_r;
  logic pin0_r, pin1_r, red_r, green_r;

  logic out_adv;
  logic s1_adv;
  logic in_acc;

  lpf_ctrl_t ctrl0, ctrl1;
  logic lvl0_nxt, lvl1_nxt, onb0_nxt, onb1_nxt;

  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_stall  = s1_valid_r && !out_adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_pin_0     = pin0_r;
  assign out_pin_1     = pin1_r;
  assign out_red_led   = red_r;
  assign out_green_led = green_r;

  always_comb begin
    ctrl0.test_on    = mode_r[FlagTestOn];
    ctrl0.test_off   = mode_r[FlagTestOff];
    ctrl0.beep_sel   = mode_r[FlagBeep0] && s1_beep_r;
    ctrl0.debug_en   = |dbg_mask_r;
    ctrl0.dbg_hit    = |(s1_dbg0_r & dbg_mask_r);
    ctrl0.onboard_en = mode_r[FlagOnboard];

    ctrl1.test_on    = mode_r[FlagTestOn];
    ctrl1.test_off   = mode_r[FlagTestOff];
    ctrl1.beep_sel   = mode_r[FlagBeep0 + 1] && s1_beep_r;
    ctrl1.debug_en   = |dbg_mask_r;
    ctrl1.dbg_hit    = |(s1_dbg1_r & dbg_mask_r);
    ctrl1.onboard_en = mode_r[FlagOnboard];
  end

  lpf_channel u_ch0 (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (s1_adv),
    .ctrl        (ctrl0),
    .period      (period0_r),
    .pattern     (pattern0_r),
    .manual      (s1_man0_r),
    .level_nxt   (lvl0_nxt),
    .onboard_nxt (onb0_nxt)
  );

  lpf_channel u_ch1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (s1_adv),
    .ctrl        (ctrl1),
    .period      (period1_r),
    .pattern     (pattern1_r),
    .manual      (s1_man1_r),
    .level_nxt   (lvl1_nxt),
    .onboard_nxt (onb1_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 7'd0;
      dbg_mask_r <= 8'd0;
      period0_r  <= 8'd0;
      pattern0_r <= 8'd0;
      period1_r  <= 8'd0;
      pattern1_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE_FLAGS: mode_r     <= cfg_data[6:0];
        CFG_DEBUG_MASK: dbg_mask_r <= cfg_data;
        CFG_PERIOD_0:   period0_r  <= cfg_data;
        CFG_PATTERN_0:  pattern0_r <= cfg_data;
        CFG_PERIOD_1:   period1_r  <= cfg_data;
        CFG_PATTERN_1:  pattern1_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_beep_r <= in_beep_active;
      s1_dbg0_r <= in_debug_bits_0;
      s1_dbg1_r <= in_debug_bits_1;
      s1_man0_r <= in_manual_level_0;
      s1_man1_r <= in_manual_level_1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pin0_r  <= lvl0_nxt ^ mode_r[FlagInvert0];
      pin1_r  <= lvl1_nxt ^ mode_r[FlagInvert0 + 1];
      red_r   <= onb0_nxt;
      green_r <= onb1_nxt;
    end
  end

  `LPF_ASSERT_NEXT(a_out_fill, clk, rst_n, s1_adv, out_valid_r)
  `LPF_ASSERT_IMPL(a_in_free, clk, rst_n, !s1_valid_r, !in_stall)

endmodule

`default_nettype wire

// ----- rtl/lpf_channel.sv -----
// one led channel: source selection, flasher counter, cursor and stored levels
`default_nettype none
`include "led_pattern_flasher_unit_defines.svh"

module lpf_channel (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  lpf_pkg::lpf_ctrl_t ctrl,
  input  logic [7:0]        period,
  input  logic [7:0]        pattern,
  input  logic [7:0]        manual,
  output logic              level_nxt,
  output logic              onboard_nxt
);
  import lpf_pkg::*;

  logic [7:0] count_r, count_nxt;
  logic [7:0] cursor_r, cursor_nxt;
  logic       level_r;
  logic       onboard_r;

  logic [7:0] period_eff;
  logic [7:0] pattern_eff;
  logic [7:0] manual_eff;
  logic [7:0] cursor_step;
  logic       manual_mode;
  logic       wr;
  logic       wr_val;

  always_comb begin
    // the beep source runs the same flasher with fixed settings
    period_eff  = ctrl.beep_sel ? BeepPeriod  : period;
    pattern_eff = ctrl.beep_sel ? BeepPattern : pattern;
    manual_eff  = ctrl.beep_sel ? BeepPeriod  : manual;
    manual_mode = period_eff > ManualPeriod;
    cursor_step = (cursor_r == 8'd1) ? CursorTop : (cursor_r >> 1);

    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    wr         = 1'b0;
    wr_val     = 1'b0;

    priority if (ctrl.test_on) begin
      wr     = 1'b1;
      wr_val = 1'b1;
    end else if (ctrl.test_off) begin
      wr     = 1'b1;
      wr_val = 1'b0;
    end else if (!ctrl.beep_sel && ctrl.debug_en) begin
      wr     = 1'b1;
      wr_val = ctrl.dbg_hit;
    end else if (manual_mode && (manual_eff > ManualHigh)) begin
      wr     = 1'b1;
      wr_val = 1'b1;
    end else if (manual_mode && (manual_eff < ManualLow)) begin
      wr     = 1'b1;
      wr_val = 1'b0;
    end else if (count_r != 8'd0) begin
      count_nxt = count_r - 8'd1;
    end else begin
      // expiry: reload, step the cursor and show the pattern bit
      count_nxt  = period_eff - 8'd1;
      cursor_nxt = cursor_step;
      wr         = 1'b1;
      wr_val     = |(cursor_step & pattern_eff);
    end

    level_nxt   = wr ? wr_val : level_r;
    onboard_nxt = (wr && ctrl.onboard_en) ? wr_val : onboard_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 8'd0;
      cursor_r  <= CursorTop;
      level_r   <= 1'b0;
      onboard_r <= 1'b0;
    end else if (upd) begin
      count_r   <= count_nxt;
      cursor_r  <= cursor_nxt;
      level_r   <= level_nxt;
      onboard_r <= onboard_nxt;
    end
  end

  `LPF_ASSERT_IMPL(a_cursor_onehot, clk, rst_n, 1'b1, $onehot(cursor_r))
  `LPF_ASSERT_NEXT(a_hold_idle, clk, rst_n, !upd, $stable(level_r) && $stable(onboard_r) && $stable(cursor_r) && $stable(count_r))

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for the led pattern flasher unit: directed and random ticks
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpf_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic pin_0;
    logic pin_1;
    logic red_led;
    logic green_led;
  } led_result_t;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_beep_active    = 1'b0;
  logic [7:0] in_debug_bits_0   = '0;
  logic [7:0] in_debug_bits_1   = '0;
  logic [7:0] in_manual_level_0 = '0;
  logic [7:0] in_manual_level_1 = '0;
  logic       out_stall         = 1'b0;
  logic       cfg_valid         = 1'b0;
  cfg_idx_t   cfg_index         = CFG_MODE_FLAGS;
  logic [7:0] cfg_data          = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_pin_0;
  logic       out_pin_1;
  logic       out_red_led;
  logic       out_green_led;
  logic       cfg_ready;

  bit          idle_on      = 1'b1;
  bit          hold_results = 1'b0;
  int          errors       = 0;
  int          results_seen = 0;
  led_result_t expected_leds[$];

  // predictor copy of the registers and channel state
  logic [6:0] m_flags      = '0;
  logic [7:0] m_mask       = '0;
  logic [7:0] m_period[2]  = '{8'd0, 8'd0};
  logic [7:0] m_pattern[2] = '{8'd0, 8'd0};
  logic [7:0] step_cnt[2]  = '{8'd0, 8'd0};
  logic [7:0] cursor[2]    = '{CursorTop, CursorTop};
  logic       level[2]     = '{1'b0, 1'b0};
  logic       onboard[2]   = '{1'b0, 1'b0};

  always #5 clk = ~clk;

  led_pattern_flasher_unit uut (.*);

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic got, logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %b want %b", results_seen, name, got, want));
  endtask

  function automatic void set_level(int ch, logic on);
    level[ch] = on;
    if (m_flags[FlagOnboard]) onboard[ch] = on;
  endfunction

  function automatic void flasher_tick(int ch, logic [7:0] period, logic [7:0] pattern,
                                       logic [7:0] manual);
    if (period > ManualPeriod && manual > ManualHigh) begin
      set_level(ch, 1'b1);
    end else if (period > ManualPeriod && manual < ManualLow) begin
      set_level(ch, 1'b0);
    end else if (step_cnt[ch] != 8'd0) begin
      step_cnt[ch] = step_cnt[ch] - 8'd1;
    end else begin
      // expiry: reload and rotate the one-hot cursor, wrapping back to the top bit
      step_cnt[ch] = period - 8'd1;
      cursor[ch] = (cursor[ch] == 8'd1) ? CursorTop : (cursor[ch] >> 1);
      set_level(ch, (cursor[ch] & pattern) != 8'd0);
    end
  endfunction

  function automatic led_result_t predict_leds(logic beep, logic [7:0] dbg0, logic [7:0] dbg1,
                                               logic [7:0] man0, logic [7:0] man1);
    logic [1:0][7:0] dbg;
    logic [1:0][7:0] man;
    led_result_t     r;
    dbg = {dbg1, dbg0};
    man = {man1, man0};
    if (m_flags[FlagTestOn]) begin
      set_level(0, 1'b1);
      set_level(1, 1'b1);
    end else if (m_flags[FlagTestOff]) begin
      set_level(0, 1'b0);
      set_level(1, 1'b0);
    end else begin
      for (int ch = 0; ch < 2; ch++) begin
        if (m_flags[FlagBeep0 + ch] && beep)
          flasher_tick(ch, BeepPeriod, BeepPattern, BeepPeriod);
        else if (m_mask != 8'd0)
          set_level(ch, (dbg[ch] & m_mask) != 8'd0);
        else
          flasher_tick(ch, m_period[ch], m_pattern[ch], man[ch]);
      end
    end
    r.pin_0     = level[0] ^ m_flags[FlagInvert0];
    r.pin_1     = level[1] ^ m_flags[FlagInvert0 + 1];
    r.red_led   = onboard[0];
    r.green_led = onboard[1];
    return r;
  endfunction

  // checks results, tracks register writes and predicts each accepted request
  always @(posedge clk) begin : monitor
    led_result_t got;
    led_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_pin_0, out_pin_1, out_red_led, out_green_led};
        if (expected_leds.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = expected_leds.pop_front();
          check_field("pin_0", got.pin_0, want.pin_0);
          check_field("pin_1", got.pin_1, want.pin_1);
          check_field("red_led", got.red_led, want.red_led);
          check_field("green_led", got.green_led, want.green_led);
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE_FLAGS: m_flags      = cfg_data[6:0];
          CFG_DEBUG_MASK: m_mask       = cfg_data;
          CFG_PERIOD_0:   m_period[0]  = cfg_data;
          CFG_PATTERN_0:  m_pattern[0] = cfg_data;
          CFG_PERIOD_1:   m_period[1]  = cfg_data;
          CFG_PATTERN_1:  m_pattern[1] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_leds.push_back(predict_leds(in_beep_active, in_debug_bits_0, in_debug_bits_1,
                                             in_manual_level_0, in_manual_level_1));
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_results = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_tick(logic beep, logic [7:0] dbg0, logic [7:0] dbg1,
                           logic [7:0] man0, logic [7:0] man1);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_beep_active    <= beep;
    in_debug_bits_0   <= dbg0;
    in_debug_bits_1   <= dbg1;
    in_manual_level_0 <= man0;
    in_manual_level_1 <= man1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // wait for a clock edge first so the monitor has queued the last accepted request
    @(posedge clk);
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(logic [6:0] mode, logic [7:0] mask, logic [7:0] per0,
                              logic [7:0] pat0, logic [7:0] per1, logic [7:0] pat1);
    wait_drained();
    write_reg(CFG_MODE_FLAGS, {1'b0, mode});
    write_reg(CFG_DEBUG_MASK, mask);
    write_reg(CFG_PERIOD_0, per0);
    write_reg(CFG_PATTERN_0, pat0);
    write_reg(CFG_PERIOD_1, per1);
    write_reg(CFG_PATTERN_1, pat1);
    cfg_valid <= 1'b0;
  endtask

  // manual levels weighted towards the override bands and their edges
  function automatic logic [7:0] pick_manual();
    unique case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(231, 255));
      2:       return ($urandom_range(0, 1) != 0) ? ManualLow : ManualHigh;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_period();
    unique case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return ManualPeriod;
      3:       return 8'($urandom_range(251, 255));
      4:       return 8'd255;
      default: return 8'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic program_random_settings();
    logic [6:0] mode;
    logic [7:0] mask;
    mode = 7'($urandom_range(0, 127));
    // keep the forcing flags rare so the flashers get most of the ticks
    mode[FlagTestOn]  = ($urandom_range(0, 7) == 0);
    mode[FlagTestOff] = ($urandom_range(0, 7) == 0);
    mask = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    program_regs(mode, mask, pick_period(), 8'($urandom_range(0, 255)),
                 pick_period(), 8'($urandom_range(0, 255)));
  endtask

  task automatic random_tick();
    send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), pick_manual(), pick_manual());
  endtask

  task automatic test_reset_state();
    send_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_tick(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_forced_levels();
    program_regs(7'h51, 8'h00, 8'd0, 8'h00, 8'd0, 8'h00);
    send_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    // both test flags: test on wins
    program_regs(7'h63, 8'hFF, 8'd1, 8'hFF, 8'd1, 8'hFF);
    send_tick(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    program_regs(7'h42, 8'h00, 8'd1, 8'hFF, 8'd1, 8'hFF);
    send_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    program_regs(7'h7F, 8'hFF, 8'd255, 8'hFF, 8'd255, 8'hFF);
    send_tick(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_debug_source();
    program_regs(7'h40, 8'hFF, 8'd1, 8'h00, 8'd1, 8'h00);
    send_tick(1'b0, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_tick(1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    program_regs(7'h40, 8'h80, 8'd1, 8'h00, 8'd1, 8'h00);
    send_tick(1'b0, 8'h7F, 8'h80, 8'h00, 8'h00);
  endtask

  task automatic test_beep_source();
    program_regs(7'h4C, 8'h00, 8'd1, 8'hFF, 8'd1, 8'h00);
    send_tick(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_tick(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    // beep on channel 0 wins over the debug source, channel 1 falls to debug
    program_regs(7'h44, 8'h01, 8'd1, 8'h00, 8'd1, 8'h00);
    send_tick(1'b1, 8'h00, 8'h01, 8'h00, 8'h00);
  endtask

  task automatic test_manual_override();
    program_regs(7'h40, 8'h00, 8'd251, 8'hAA, 8'd255, 8'h55);
    send_tick(1'b0, 8'h00, 8'h00, 8'd231, 8'd255);
    send_tick(1'b0, 8'h00, 8'h00, 8'd9, 8'd0);
    // mid band: the flasher runs with the manual period as given
    send_tick(1'b0, 8'h00, 8'h00, ManualLow, ManualHigh);
    program_regs(7'h40, 8'h00, ManualPeriod, 8'hAA, ManualPeriod, 8'h55);
    send_tick(1'b0, 8'h00, 8'h00, 8'd255, 8'd0);
  endtask

  task automatic test_flasher_steps();
    // period 1 steps every tick, so the cursor wraps; period 0 reloads 255
    program_regs(7'h40, 8'h00, 8'd1, 8'hA5, 8'd0, 8'hFF);
    repeat (9) send_tick(1'b0, 8'h00, 8'h00, 8'h80, 8'h80);
    // onboard copies hold once their flag is cleared
    program_regs(7'h00, 8'h00, 8'd1, 8'hA5, 8'd1, 8'h5A);
    repeat (2) send_tick(1'b0, 8'h00, 8'h00, 8'h80, 8'h80);
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 0)
        program_regs(7'h00, 8'h00, 8'd0, 8'h00, 8'd0, 8'h00);
      else if (phase == 1)
        program_regs(7'h7F, 8'hFF, 8'd255, 8'hFF, 8'd255, 8'hFF);
      else
        program_random_settings();
      repeat (50) random_tick();
    end
  endtask

  task automatic test_result_backpressure();
    program_regs(7'h40, 8'h00, 8'd1, 8'($urandom_range(0, 255)), 8'd2,
                 8'($urandom_range(0, 255)));
    hold_results = 1'b1;
    repeat (40) random_tick();
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    program_random_settings();
    repeat (60) random_tick();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_forced_levels();
    test_debug_source();
    test_beep_source();
    test_manual_override();
    test_flasher_steps();
    test_random_settings();
    test_result_backpressure();
    test_streaming();
    wait_drained();
    repeat (5) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
